@@ sv/tpt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TLB page table translator package
// Shared sizes, default parameter values and the TLB control bundle.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int TLB_SIZE_DEF    = 16;
  localparam int PAGE_BITS_DEF   = 8;
  localparam int OFFSET_BITS_DEF = 8;

  localparam int ADDR_W      = 16;
  localparam int FRAME_OUT_W = 8;
  localparam int PADDR_W     = 16;
  localparam int CNT_W       = 32;

  localparam int M_TDATA_W = 88;
  localparam int M_TUSER_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic upd;
    logic hit;
  } tlb_ctl_t;

endpackage
`default_nettype wire

@@ sv/tpt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TLB page table translator front end
// Accepts address transfers, splits them into page and offset and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tpt_front import tpt_pkg::*; #(
  parameter int PAGE_BITS   = PAGE_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [ADDR_W-1:0]      s_tdata,
  output logic                   q_valid,
  input  logic                   q_pop,
  output logic [PAGE_BITS-1:0]   q_page,
  output logic [OFFSET_BITS-1:0] q_offset
);

  localparam int EXT_W  = ADDR_W + PAGE_BITS + OFFSET_BITS;
  localparam int SLOT_W = PAGE_BITS + OFFSET_BITS;
  localparam logic [1:0] QDEPTH = 2'd2;

  logic [EXT_W-1:0]       addr_ext;
  logic [EXT_W-1:0]       addr_shr;
  logic [PAGE_BITS-1:0]   in_page;
  logic [OFFSET_BITS-1:0] in_offset;
  logic [SLOT_W-1:0]      slot [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  logic                   push;

  assign addr_ext  = EXT_W'(s_tdata);
  assign addr_shr  = addr_ext >> OFFSET_BITS;
  assign in_page   = addr_shr[PAGE_BITS-1:0];
  assign in_offset = addr_ext[OFFSET_BITS-1:0];

  assign s_tready = (count != QDEPTH);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign {q_page, q_offset} = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= {in_page, in_offset};
    end
  end

endmodule
`default_nettype wire

@@ sv/tpt_tlb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TLB page table translator TLB
// Entries kept oldest first; parallel lookup over the valid entries and an
// update that moves a hit to the newest end or appends with eviction.
// ----------------------------------------------------------------------------
module tpt_tlb import tpt_pkg::*; #(
  parameter int TLB_SIZE  = TLB_SIZE_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [PAGE_BITS-1:0]         lk_page,
  output logic                         lk_hit,
  output logic [$clog2(TLB_SIZE)-1:0]  lk_pos,
  output logic [PAGE_BITS:0]           lk_frame,
  input  tlb_ctl_t                     ctl,
  input  logic [$clog2(TLB_SIZE)-1:0]  upd_pos,
  input  logic [PAGE_BITS-1:0]         upd_page,
  input  logic [PAGE_BITS:0]           upd_frame
);

  localparam int POS_W   = $clog2(TLB_SIZE);
  localparam int FILL_W  = $clog2(TLB_SIZE + 1);
  localparam int FRAME_W = PAGE_BITS + 1;

  logic [PAGE_BITS-1:0] pages  [TLB_SIZE];
  logic [FRAME_W-1:0]   frames [TLB_SIZE];
  logic [FILL_W-1:0]    fill;
  logic [TLB_SIZE-1:0]  match;
  logic                 full;
  logic                 rem;
  logic [POS_W-1:0]     rm_pos;
  logic [FILL_W-1:0]    fill_rem;

  always_comb begin
    lk_hit   = 1'b0;
    lk_pos   = '0;
    lk_frame = '0;
    for (int k = 0; k < TLB_SIZE; k++) begin
      match[k] = (FILL_W'(k) < fill) && (pages[k] == lk_page);
    end
    for (int k = TLB_SIZE - 1; k >= 0; k--) begin
      if (match[k]) begin
        lk_hit   = 1'b1;
        lk_pos   = POS_W'(k);
        lk_frame = frames[k];
      end
    end
  end

  assign full     = (fill == FILL_W'(TLB_SIZE));
  assign rem      = ctl.hit || full;
  assign rm_pos   = ctl.hit ? upd_pos : '0;
  assign fill_rem = rem ? fill - FILL_W'(1) : fill;

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      for (int k = 0; k < TLB_SIZE; k++) begin
        if (FILL_W'(k) == fill_rem) begin
          pages[k]  <= upd_page;
          frames[k] <= upd_frame;
        end else if (rem && (POS_W'(k) >= rm_pos) && (FILL_W'(k + 1) < fill)) begin
          pages[k]  <= pages[(k < TLB_SIZE - 1) ? k + 1 : k];
          frames[k] <= frames[(k < TLB_SIZE - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.upd) begin
      fill <= fill_rem + FILL_W'(1);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TLB_SIZE))
    else $error("TLB fill count beyond capacity");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    lk_hit |-> (FILL_W'(lk_pos) < fill))
    else $error("TLB hit reported on an unfilled entry");

endmodule
`default_nettype wire

@@ sv/tpt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TLB page table translator back end
// Sequences each queued page through TLB lookup, page table read, fault
// allocation, TLB update and the counters, and drives the output register.
// ----------------------------------------------------------------------------
module tpt_back import tpt_pkg::*; #(
  parameter int TLB_SIZE    = TLB_SIZE_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  logic [PAGE_BITS-1:0]         q_page,
  input  logic [OFFSET_BITS-1:0]       q_offset,
  output logic [PAGE_BITS-1:0]         lk_page,
  input  logic                         lk_hit,
  input  logic [$clog2(TLB_SIZE)-1:0]  lk_pos,
  input  logic [PAGE_BITS:0]           lk_frame,
  output tlb_ctl_t                     tlb_ctl,
  output logic [$clog2(TLB_SIZE)-1:0]  upd_pos,
  output logic [PAGE_BITS-1:0]         upd_page,
  output logic [PAGE_BITS:0]           upd_frame,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [M_TDATA_W-1:0]         m_tdata,
  output logic [M_TUSER_W-1:0]         m_tuser
);

  localparam int POS_W     = $clog2(TLB_SIZE);
  localparam int FRAME_W   = PAGE_BITS + 1;
  localparam int NUM_PAGES = 1 << PAGE_BITS;
  localparam int EXT_W     = FRAME_W + OFFSET_BITS + PADDR_W;

  localparam logic [1:0] ST_CLEAR   = 2'd0;
  localparam logic [1:0] ST_LOOK    = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [PAGE_BITS-1:0]   clr_addr;
  logic [FRAME_W-1:0]     next_free;
  logic [CNT_W-1:0]       hit_cnt;
  logic [CNT_W-1:0]       fault_cnt;

  logic [PAGE_BITS-1:0]   st_page;
  logic [OFFSET_BITS-1:0] st_offset;
  logic                   st_hit;
  logic [POS_W-1:0]       st_pos;
  logic [FRAME_W-1:0]     st_frame;

  logic [FRAME_W:0]       pt_mem [NUM_PAGES];
  logic [FRAME_W:0]       rd_row;
  logic                   mem_we;
  logic [PAGE_BITS-1:0]   mem_waddr;
  logic [FRAME_W:0]       mem_wdata;
  logic                   mem_re;

  logic                   go;
  logic                   load;
  logic                   rd_present;
  logic                   fault;
  logic [FRAME_W-1:0]     frame_sel;
  logic [EXT_W-1:0]       frame_ext;
  logic [EXT_W-1:0]       paddr_ext;

  logic [FRAME_OUT_W-1:0] out_frame;
  logic [PADDR_W-1:0]     out_paddr;
  logic                   out_hit;
  logic                   out_fault;

  assign lk_page    = q_page;
  assign go         = !m_tvalid || m_tready;
  assign load       = (state == ST_RESOLVE) && go;
  assign rd_present = rd_row[FRAME_W];
  assign fault      = !st_hit && !rd_present;

  always_comb begin
    if (st_hit) begin
      frame_sel = st_frame;
    end else if (rd_present) begin
      frame_sel = rd_row[FRAME_W-1:0];
    end else begin
      frame_sel = next_free;
    end
  end

  assign frame_ext = EXT_W'(frame_sel);
  assign paddr_ext = (frame_ext << OFFSET_BITS) | EXT_W'(st_offset);

  assign q_pop       = load;
  assign tlb_ctl.upd = load;
  assign tlb_ctl.hit = st_hit;
  assign upd_pos     = st_pos;
  assign upd_page    = st_page;
  assign upd_frame   = frame_sel;

  assign mem_re = (state == ST_LOOK) && q_valid;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (load && fault) begin
      mem_we    = 1'b1;
      mem_waddr = st_page;
      mem_wdata = {1'b1, next_free};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pt_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row <= pt_mem[q_page];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (q_valid) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (go) begin
          state_next = ST_LOOK;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      next_free <= '0;
      hit_cnt   <= '0;
      fault_cnt <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + PAGE_BITS'(1);
      end
      if (load) begin
        m_tvalid <= 1'b1;
        if (st_hit && (hit_cnt != CNT_MAX)) begin
          hit_cnt <= hit_cnt + CNT_W'(1);
        end
        if (fault) begin
          next_free <= next_free + FRAME_W'(1);
          if (fault_cnt != CNT_MAX) begin
            fault_cnt <= fault_cnt + CNT_W'(1);
          end
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      st_page   <= q_page;
      st_offset <= q_offset;
      st_hit    <= lk_hit;
      st_pos    <= lk_pos;
      st_frame  <= lk_frame;
    end
    if (load) begin
      out_frame <= frame_ext[FRAME_OUT_W-1:0];
      out_paddr <= paddr_ext[PADDR_W-1:0];
      out_hit   <= st_hit;
      out_fault <= fault;
    end
  end

  assign m_tdata = {fault_cnt, hit_cnt, out_paddr, out_frame};
  assign m_tuser = {out_fault, out_hit};

  a_hit_xor_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_hit && out_fault))
    else $error("Result flagged as both TLB hit and page fault");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!q_pop && !tlb_ctl.upd && !m_tvalid))
    else $error("Item processed during page table clearing");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> (m_tvalid && (state == ST_LOOK)))
    else $error("Resolved item did not reach the output register");

  a_look_needs_item: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) && !q_valid |=> (state == ST_LOOK))
    else $error("Lookup advanced without a queued item");

endmodule
`default_nettype wire

@@ sv/tlb_page_table_translator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TLB page table translator
// Translates 16-bit logical addresses through an LRU TLB and a demand-paged
// page table, allocating frames in sequence on page faults.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transfer on s_* carries one logical address; each output
//   transfer on m_* carries the frame, physical address, the TLB hit and
//   page fault flags and the saturating hit and fault totals.
//   Path: with an idle block and a ready receiver, an input transfer is
//   queued, then passes lookup and resolve before m_tvalid rises.
//   Items: the back end takes one item at a time, in lookup for the TLB
//   compare and the registered page table read, then in resolve for fault
//   allocation, the TLB update and the output register load.
//   Reset: the TLB is emptied, the counters and frame allocator go to zero,
//   and the page table is cleared in a pass over all 2**PAGE_BITS rows (256 by
//   default). Input transfers are queued (two entries) but not processed
//   until that pass ends.
//   Stall: the output register holds its result while m_tready is low; the
//   back end waits with the next item and the two-entry queue keeps
//   accepting until it is full.
// ----------------------------------------------------------------------------
module tlb_page_table_translator import tpt_pkg::*; #(
  parameter int TLB_SIZE    = TLB_SIZE_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ADDR_W-1:0]    s_tdata,   // [15:0] logical_address
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] frame, [23:8] physical_address,
                                          // [55:24] hit_total, [87:56] fault_total
  output logic [M_TUSER_W-1:0] m_tuser    // [0] tlb_hit, [1] page_fault
);

  localparam int POS_W = $clog2(TLB_SIZE);

  logic                   q_valid;
  logic                   q_pop;
  logic [PAGE_BITS-1:0]   q_page;
  logic [OFFSET_BITS-1:0] q_offset;
  logic [PAGE_BITS-1:0]   lk_page;
  logic                   lk_hit;
  logic [POS_W-1:0]       lk_pos;
  logic [PAGE_BITS:0]     lk_frame;
  tlb_ctl_t               tlb_ctl;
  logic [POS_W-1:0]       upd_pos;
  logic [PAGE_BITS-1:0]   upd_page;
  logic [PAGE_BITS:0]     upd_frame;

  tpt_front #(
    .PAGE_BITS   (PAGE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_page   (q_page),
    .q_offset (q_offset)
  );

  tpt_tlb #(
    .TLB_SIZE  (TLB_SIZE),
    .PAGE_BITS (PAGE_BITS)
  ) u_tlb (
    .clk       (clk),
    .rst       (rst),
    .lk_page   (lk_page),
    .lk_hit    (lk_hit),
    .lk_pos    (lk_pos),
    .lk_frame  (lk_frame),
    .ctl       (tlb_ctl),
    .upd_pos   (upd_pos),
    .upd_page  (upd_page),
    .upd_frame (upd_frame)
  );

  tpt_back #(
    .TLB_SIZE    (TLB_SIZE),
    .PAGE_BITS   (PAGE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_page    (q_page),
    .q_offset  (q_offset),
    .lk_page   (lk_page),
    .lk_hit    (lk_hit),
    .lk_pos    (lk_pos),
    .lk_frame  (lk_frame),
    .tlb_ctl   (tlb_ctl),
    .upd_pos   (upd_pos),
    .upd_page  (upd_page),
    .upd_frame (upd_frame),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire
